>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/lsc_pkg.sv
// shared types and constants of the line segment clipper
package lsc_pkg;

  localparam int COORD_BITS = 16;
  localparam int MAX_PASSES = 4;

  // internal coordinates grow at most threefold per pass on an inverted window
  localparam int IW = COORD_BITS + 2 * MAX_PASSES + 1;
  localparam int EXT = IW - COORD_BITS;
  localparam int DW = IW + 1;
  localparam int RW = DW + 2;
  localparam int STEP_BITS = $clog2(DW);
  localparam int PASS_BITS = $clog2(MAX_PASSES + 1);
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WIN_LEFT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIN_BOTTOM = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIN_RIGHT = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIN_TOP = 2'd3;

  localparam logic signed [COORD_BITS-1:0] WIN_LEFT_RESET = COORD_BITS'(0);
  localparam logic signed [COORD_BITS-1:0] WIN_BOTTOM_RESET = COORD_BITS'(0);
  localparam logic signed [COORD_BITS-1:0] WIN_RIGHT_RESET = COORD_BITS'(639);
  localparam logic signed [COORD_BITS-1:0] WIN_TOP_RESET = COORD_BITS'(479);

  localparam logic [3:0] CODE_ABOVE = 4'b1000;
  localparam logic [3:0] CODE_BELOW = 4'b0100;
  localparam logic [3:0] CODE_RIGHT = 4'b0010;
  localparam logic [3:0] CODE_LEFT = 4'b0001;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } seg_t;

  typedef struct packed {
    logic                         accepted;
    logic signed [COORD_BITS-1:0] clip_start_x;
    logic signed [COORD_BITS-1:0] clip_start_y;
    logic signed [COORD_BITS-1:0] clip_end_x;
    logic signed [COORD_BITS-1:0] clip_end_y;
  } clip_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic prep;
    logic step;
    logic update;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_window;
    logic reject;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> src/lsc_ctrl.sv
// sequencer of the clipper: passes, divider steps and result hand-off
module lsc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               seg_valid,
  input  lsc_pkg::dp_status_t status,
  output lsc_pkg::ctrl_cmd_t  cmd,
  output logic               busy
);
  import lsc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EVAL   = 6'b000010,
    S_PREP   = 6'b000100,
    S_DIV    = 6'b001000,
    S_UPDATE = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (seg_valid) begin
          cmd.load = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.in_window || status.reject) begin
          state_next = S_DONE;
        end else begin
          cmd.setup = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_EVAL;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/lsc_dpath.sv
// window registers, endpoint registers, serial scale-divide unit and result register
module lsc_dpath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lsc_pkg::ctrl_cmd_t                    cmd,
  output lsc_pkg::dp_status_t                   status,
  input  lsc_pkg::seg_t                         seg,
  input  logic                                  cfg_valid,
  input  logic [lsc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] cfg_data,
  input  logic                                  clip_stall,
  output logic                                  clip_valid,
  output lsc_pkg::clip_t                        clip
);
  import lsc_pkg::*;

  typedef logic signed [IW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;

  logic signed [COORD_BITS-1:0] win_left;
  logic signed [COORD_BITS-1:0] win_bottom;
  logic signed [COORD_BITS-1:0] win_right;
  logic signed [COORD_BITS-1:0] win_top;

  coord_t x1, y1, x2, y2;
  logic [PASS_BITS-1:0] pass_cnt;

  coord_t left_ext, bottom_ext, right_ext, top_ext;
  logic [3:0] c1, c2, pick;

  // per-pass operands
  diff_t off_r, oth_r, span_r;
  coord_t base_r, edge_r;
  logic horiz_r, move_first_r;

  // divider state
  logic [DW-1:0] a_r, b_r, c_r, q_r, r_r;
  logic neg_r, zero_r;
  logic [STEP_BITS-1:0] step_cnt;

  logic [DW-1:0] mag_off, mag_oth, mag_span;
  logic [RW-1:0] r_sum, r_c1, r_c2;
  logic [RW-1:0] r_next;
  logic [1:0] q_inc;
  logic signed [DW:0] q_signed, new_wide;
  coord_t new_c;

  function automatic coord_t ext_win(logic signed [COORD_BITS-1:0] w);
    return {{EXT{w[COORD_BITS-1]}}, w};
  endfunction

  function automatic diff_t widen(coord_t v);
    return {v[IW-1], v};
  endfunction

  function automatic logic [DW-1:0] mag(diff_t v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  assign left_ext = ext_win(win_left);
  assign bottom_ext = ext_win(win_bottom);
  assign right_ext = ext_win(win_right);
  assign top_ext = ext_win(win_top);

  function automatic logic [3:0] region(coord_t x, coord_t y, coord_t lo_x, coord_t lo_y,
                                         coord_t hi_x, coord_t hi_y);
    logic [3:0] code;
    code = '0;
    if (y > hi_y) code = code | CODE_ABOVE;
    if (y < lo_y) code = code | CODE_BELOW;
    if (x > hi_x) code = code | CODE_RIGHT;
    if (x < lo_x) code = code | CODE_LEFT;
    return code;
  endfunction

  assign c1 = region(x1, y1, left_ext, bottom_ext, right_ext, top_ext);
  assign c2 = region(x2, y2, left_ext, bottom_ext, right_ext, top_ext);
  assign pick = (c1 != 4'd0) ? c1 : c2;

  assign status.in_window = (c1 == 4'd0) && (c2 == 4'd0);
  assign status.reject = ((c1 & c2) != 4'd0) || (pass_cnt == PASS_BITS'(MAX_PASSES));
  assign status.div_last = (step_cnt == '0);
  assign status.out_free = !clip_valid || !clip_stall;

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_left <= WIN_LEFT_RESET;
      win_bottom <= WIN_BOTTOM_RESET;
      win_right <= WIN_RIGHT_RESET;
      win_top <= WIN_TOP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIN_LEFT:   win_left <= cfg_data;
        REG_WIN_BOTTOM: win_bottom <= cfg_data;
        REG_WIN_RIGHT:  win_right <= cfg_data;
        REG_WIN_TOP:    win_top <= cfg_data;
        default: ;
      endcase
    end
  end

  assign mag_off = mag(off_r);
  assign mag_oth = mag(oth_r);
  assign mag_span = mag(span_r);

  // one quotient bit per step: r = 2r + bit*a, then up to two subtractions of c
  always_comb begin
    r_sum = {1'b0, r_r, 1'b0} + (b_r[step_cnt] ? {2'b00, a_r} : RW'(0));
    r_c1 = {2'b00, c_r};
    r_c2 = {1'b0, c_r, 1'b0};
    if (r_sum >= r_c2) begin
      r_next = r_sum - r_c2;
      q_inc = 2'd2;
    end else if (r_sum >= r_c1) begin
      r_next = r_sum - r_c1;
      q_inc = 2'd1;
    end else begin
      r_next = r_sum;
      q_inc = 2'd0;
    end
  end

  always_comb begin
    if (zero_r) begin
      q_signed = '0;
    end else if (neg_r) begin
      q_signed = -$signed({1'b0, q_r});
    end else begin
      q_signed = $signed({1'b0, q_r});
    end
    new_wide = {{2{base_r[IW-1]}}, base_r} + q_signed;
    new_c = new_wide[IW-1:0];
  end

  // endpoints and pass count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1 <= ext_win(seg.start_x);
      y1 <= ext_win(seg.start_y);
      x2 <= ext_win(seg.end_x);
      y2 <= ext_win(seg.end_y);
      pass_cnt <= '0;
    end else if (cmd.update) begin
      pass_cnt <= pass_cnt + PASS_BITS'(1);
      if (move_first_r) begin
        x1 <= horiz_r ? new_c : edge_r;
        y1 <= horiz_r ? edge_r : new_c;
      end else begin
        x2 <= horiz_r ? new_c : edge_r;
        y2 <= horiz_r ? edge_r : new_c;
      end
    end
  end

  // operand selection, edges tried top, bottom, left, right
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      move_first_r <= (c1 != 4'd0);
      if ((pick & CODE_ABOVE) != 4'd0) begin
        horiz_r <= 1'b1;
        edge_r <= top_ext;
        base_r <= x1;
        off_r <= widen(top_ext) - widen(y1);
        oth_r <= widen(x2) - widen(x1);
        span_r <= widen(y2) - widen(y1);
      end else if ((pick & CODE_BELOW) != 4'd0) begin
        horiz_r <= 1'b1;
        edge_r <= bottom_ext;
        base_r <= x1;
        off_r <= widen(bottom_ext) - widen(y1);
        oth_r <= widen(x2) - widen(x1);
        span_r <= widen(y2) - widen(y1);
      end else if ((pick & CODE_LEFT) != 4'd0) begin
        horiz_r <= 1'b0;
        edge_r <= left_ext;
        base_r <= y1;
        off_r <= widen(left_ext) - widen(x1);
        oth_r <= widen(y2) - widen(y1);
        span_r <= widen(x2) - widen(x1);
      end else begin
        horiz_r <= 1'b0;
        edge_r <= right_ext;
        base_r <= y1;
        off_r <= widen(right_ext) - widen(x1);
        oth_r <= widen(y2) - widen(y1);
        span_r <= widen(x2) - widen(x1);
      end
    end
  end

  // divider
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      a_r <= (mag_off > mag_span) ? mag_span : mag_off;
      b_r <= mag_oth;
      c_r <= mag_span;
      neg_r <= off_r[DW-1] ^ oth_r[DW-1] ^ span_r[DW-1];
      zero_r <= (mag_span == '0);
      r_r <= '0;
      q_r <= '0;
      step_cnt <= STEP_BITS'(DW - 1);
    end else if (cmd.step) begin
      r_r <= r_next[DW-1:0];
      q_r <= {q_r[DW-2:0], 1'b0} + DW'(q_inc);
      step_cnt <= step_cnt - STEP_BITS'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_valid <= 1'b0;
    end else if (cmd.emit) begin
      clip_valid <= 1'b1;
    end else if (!clip_stall) begin
      clip_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      clip.accepted <= status.in_window;
      clip.clip_start_x <= status.in_window ? x1[COORD_BITS-1:0] : '0;
      clip.clip_start_y <= status.in_window ? y1[COORD_BITS-1:0] : '0;
      clip.clip_end_x <= status.in_window ? x2[COORD_BITS-1:0] : '0;
      clip.clip_end_y <= status.in_window ? y2[COORD_BITS-1:0] : '0;
    end
  end

endmodule

>>> src/line_segment_clipper.sv
// top level of the line segment clipper
//
//  channel  signals                            transfer when
//  seg      seg_valid, seg_stall, seg          seg_valid && !seg_stall
//  clip     clip_valid, clip_stall, clip       clip_valid && !clip_stall
//  cfg      cfg_valid, cfg_ready, cfg_index,   cfg_valid && cfg_ready
//           cfg_data
//
// one segment at a time: the next seg transfer is possible once the sequencer is
// back in idle, after 0 to MAX_PASSES clip passes
// each clip pass is edge selection with operand setup, divider preparation, the
// steps of the serial scale-divide unit and endpoint update
// rst is synchronous; it clears the sequencer, the result valid and the window
// registers (0, 0, 639, 479)
// a stalled result sits in the clip register while the next segment is taken
module line_segment_clipper (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  seg_valid,
  output logic                                  seg_stall,
  input  lsc_pkg::seg_t                         seg,
  output logic                                  clip_valid,
  input  logic                                  clip_stall,
  output lsc_pkg::clip_t                        clip,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lsc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic signed [lsc_pkg::COORD_BITS-1:0] cfg_data
);
  import lsc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       busy;

  // window writes must arrive only while idle, a rule on the user that the block does not enforce; all are taken
  assign cfg_ready = 1'b1;

  // a segment is taken only while the sequencer sits idle
  assign seg_stall = busy;

  lsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .seg_valid (seg_valid),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  lsc_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .seg        (seg),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .clip_stall (clip_stall),
    .clip_valid (clip_valid),
    .clip       (clip)
  );

endmodule

>>> src/lsc_checker.sv
// port-level checks of the line segment clipper and their binding
`include "assert_macros.svh"

module lsc_checker (
  input logic           clk,
  input logic           rst,
  input logic           seg_valid,
  input logic           seg_stall,
  input logic           clip_valid,
  input logic           clip_stall,
  input lsc_pkg::clip_t clip
);
  import lsc_pkg::*;

  logic [4*COORD_BITS-1:0] clip_coords;

  assign clip_coords = {clip.clip_start_x, clip.clip_start_y, clip.clip_end_x, clip.clip_end_y};

  // a taken segment keeps the block busy for at least the next cycle
  `ASSERT_NEXT(a_busy_after_take, clk, rst, seg_valid && !seg_stall, seg_stall)

  // a rejected segment reports all-zero coordinates
  `ASSERT_IMPLY(a_reject_zero, clk, rst, clip_valid && !clip.accepted, clip_coords == '0)

  // a stalled result holds
  `ASSERT_NEXT(a_result_hold, clk, rst, clip_valid && clip_stall, clip_valid && $stable(clip))

  // reset empties the result register
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !clip_valid)

endmodule

bind line_segment_clipper lsc_checker u_lsc_checker (.*);
